@@ hw/rtl/rbi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared constants for the ray versus box hit test: the axis count and the
// fixed position of each axis in the per-axis arrays.
// ----------------------------------------------------------------------------
package rbi_pkg;

  // Number of spatial axes handled side by side.
  localparam int unsigned NumAxes = 3;

  // Position of each axis inside the per-axis packed arrays.
  localparam int unsigned AxisX = 0;
  localparam int unsigned AxisY = 1;
  localparam int unsigned AxisZ = 2;

endpackage

@@ hw/rtl/ray_box_intersection_test.sv @@
// ----------------------------------------------------------------------------
// ray_box_intersection_test
// Ray versus axis-aligned box hit test by separating axes, four-stage
// pipeline with valid/ready handshakes on both sides.
// ----------------------------------------------------------------------------
// The block accepts one box/ray word per clock cycle while the output is not
// stalled and returns one hit bit per word, in order. The four register
// stages are offset and extent forming, the multiplier stage (twelve products
// with operands of up to COORD_WIDTH+3 bits each), cross-product magnitude
// and extent sums, and the final compare. Every stage holds its word while
// the output is stalled. Ready runs combinationally back through all
// stages, so an empty stage keeps taking words, a completely full pipeline
// stalls its input in the same cycle as the output, and no word is lost.
// Results are exact: all intermediate values are doubled integers with no
// rounding.
module ray_box_intersection_test
  import rbi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [COORD_WIDTH-1:0]  box_min_x_i,
  input  logic [COORD_WIDTH-1:0]  box_min_y_i,
  input  logic [COORD_WIDTH-1:0]  box_min_z_i,
  input  logic [COORD_WIDTH-1:0]  box_max_x_i,
  input  logic [COORD_WIDTH-1:0]  box_max_y_i,
  input  logic [COORD_WIDTH-1:0]  box_max_z_i,
  input  logic [COORD_WIDTH-1:0]  origin_x_i,
  input  logic [COORD_WIDTH-1:0]  origin_y_i,
  input  logic [COORD_WIDTH-1:0]  origin_z_i,
  input  logic [COORD_WIDTH-1:0]  dir_x_i,
  input  logic [COORD_WIDTH-1:0]  dir_y_i,
  input  logic [COORD_WIDTH-1:0]  dir_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o
);

  logic [NumAxes-1:0][COORD_WIDTH-1:0]    lo, hi, org, dir;
  logic                                   prep_valid, prep_ready;
  logic [NumAxes-1:0][COORD_WIDTH+2:0]    prep_df;
  logic [NumAxes-1:0][COORD_WIDTH:0]      prep_ex;
  logic [NumAxes-1:0][COORD_WIDTH-1:0]    prep_dir, prep_mag;
  logic                                   mul_valid, mul_ready;
  logic [NumAxes-1:0]                     mul_miss;
  logic [NumAxes-1:0][2*COORD_WIDTH+2:0]  mul_pa, mul_pb;
  logic [NumAxes-1:0][2*COORD_WIDTH+1:0]  mul_ra, mul_rb;

  // Gather the input fields into per-axis arrays.
  always_comb begin
    lo[AxisX]  = box_min_x_i;
    lo[AxisY]  = box_min_y_i;
    lo[AxisZ]  = box_min_z_i;
    hi[AxisX]  = box_max_x_i;
    hi[AxisY]  = box_max_y_i;
    hi[AxisZ]  = box_max_z_i;
    org[AxisX] = origin_x_i;
    org[AxisY] = origin_y_i;
    org[AxisZ] = origin_z_i;
    dir[AxisX] = dir_x_i;
    dir[AxisY] = dir_y_i;
    dir[AxisZ] = dir_z_i;
  end

  // Offset and extent stage.
  rbi_prep #(
    .CoordWidth(COORD_WIDTH)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .lo_i      (lo),
    .hi_i      (hi),
    .org_i     (org),
    .dir_i     (dir),
    .valid_o   (prep_valid),
    .ready_i   (prep_ready),
    .df_o      (prep_df),
    .ex_o      (prep_ex),
    .dir_o     (prep_dir),
    .dir_mag_o (prep_mag)
  );

  // Slab tests and cross-axis products.
  rbi_mul #(
    .CoordWidth(COORD_WIDTH)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (prep_valid),
    .ready_o   (prep_ready),
    .df_i      (prep_df),
    .ex_i      (prep_ex),
    .dir_i     (prep_dir),
    .dir_mag_i (prep_mag),
    .valid_o   (mul_valid),
    .ready_i   (mul_ready),
    .miss_o    (mul_miss),
    .pa_o      (mul_pa),
    .pb_o      (mul_pb),
    .ra_o      (mul_ra),
    .rb_o      (mul_rb)
  );

  // Magnitudes, sums and final verdict.
  rbi_cmp #(
    .CoordWidth(COORD_WIDTH)
  ) u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .miss_i  (mul_miss),
    .pa_i    (mul_pa),
    .pb_i    (mul_pb),
    .ra_i    (mul_ra),
    .rb_i    (mul_rb),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .hit_o   (hit_o)
  );

  // The input side only stalls when every stage is full and the output waits.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (prep_valid && mul_valid && out_valid_o && !out_ready_i))
    else $error("input stalled while the pipeline has room");

endmodule

@@ hw/rtl/rbi_prep.sv @@
// ----------------------------------------------------------------------------
// rbi_prep
// First pipeline stage: forms the doubled origin-to-centre offset, the
// doubled box extent and the direction magnitude for each axis.
// ----------------------------------------------------------------------------
module rbi_prep
  import rbi_pkg::*;
#(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [NumAxes-1:0][CoordWidth-1:0]     lo_i,
  input  logic [NumAxes-1:0][CoordWidth-1:0]     hi_i,
  input  logic [NumAxes-1:0][CoordWidth-1:0]     org_i,
  input  logic [NumAxes-1:0][CoordWidth-1:0]     dir_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [NumAxes-1:0][CoordWidth+2:0]     df_o,
  output logic [NumAxes-1:0][CoordWidth:0]       ex_o,
  output logic [NumAxes-1:0][CoordWidth-1:0]     dir_o,
  output logic [NumAxes-1:0][CoordWidth-1:0]     dir_mag_o
);

  localparam int unsigned DW = CoordWidth + 3;
  localparam int unsigned EW = CoordWidth + 1;

  logic                                  valid_q;
  logic [NumAxes-1:0][DW-1:0]            df_d, df_q;
  logic [NumAxes-1:0][EW-1:0]            ex_d, ex_q;
  logic [NumAxes-1:0][CoordWidth-1:0]    dir_q;
  logic [NumAxes-1:0][CoordWidth-1:0]    mag_d, mag_q;
  logic [NumAxes-1:0][DW-1:0]            lo_w, hi_w, org_w;

  // The stage takes a new word when it is empty or its word moves on.
  assign ready_o = !valid_q || ready_i;

  // Per-axis offset, extent and magnitude; all sums fit, so two's
  // complement wraparound never occurs.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      lo_w[a]  = {{3{lo_i[a][CoordWidth-1]}}, lo_i[a]};
      hi_w[a]  = {{3{hi_i[a][CoordWidth-1]}}, hi_i[a]};
      org_w[a] = {{3{org_i[a][CoordWidth-1]}}, org_i[a]};
      df_d[a]  = {org_w[a][DW-2:0], 1'b0} - lo_w[a] - hi_w[a];
      ex_d[a]  = hi_w[a][EW-1:0] - lo_w[a][EW-1:0];
      mag_d[a] = dir_i[a][CoordWidth-1] ? (~dir_i[a] + 1'b1) : dir_i[a];
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      df_q  <= df_d;
      ex_q  <= ex_d;
      dir_q <= dir_i;
      mag_q <= mag_d;
    end
  end

  assign valid_o   = valid_q;
  assign df_o      = df_q;
  assign ex_o      = ex_q;
  assign dir_o     = dir_q;
  assign dir_mag_o = mag_q;

endmodule

@@ hw/rtl/rbi_mul.sv @@
// ----------------------------------------------------------------------------
// rbi_mul
// Second pipeline stage: the three slab tests and the twelve products of the
// cross-axis tests, each product registered on its own.
// ----------------------------------------------------------------------------
module rbi_mul
  import rbi_pkg::*;
#(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [NumAxes-1:0][CoordWidth+2:0]     df_i,
  input  logic [NumAxes-1:0][CoordWidth:0]       ex_i,
  input  logic [NumAxes-1:0][CoordWidth-1:0]     dir_i,
  input  logic [NumAxes-1:0][CoordWidth-1:0]     dir_mag_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [NumAxes-1:0]                     miss_o,
  output logic [NumAxes-1:0][2*CoordWidth+2:0]   pa_o,
  output logic [NumAxes-1:0][2*CoordWidth+2:0]   pb_o,
  output logic [NumAxes-1:0][2*CoordWidth+1:0]   ra_o,
  output logic [NumAxes-1:0][2*CoordWidth+1:0]   rb_o
);

  localparam int unsigned DW = CoordWidth + 3;
  localparam int unsigned EW = CoordWidth + 1;
  localparam int unsigned PW = 2 * CoordWidth + 3;
  localparam int unsigned RW = 2 * CoordWidth + 2;

  logic                          valid_q;
  logic [NumAxes-1:0]            miss_d, miss_q;
  logic [NumAxes-1:0][DW-1:0]    df_mag;
  logic [NumAxes-1:0]            away;
  logic signed [PW-1:0]          pa_d [NumAxes];
  logic signed [PW-1:0]          pb_d [NumAxes];
  logic signed [RW-1:0]          ra_d [NumAxes];
  logic signed [RW-1:0]          rb_d [NumAxes];
  logic [NumAxes-1:0][PW-1:0]    pa_q, pb_q;
  logic [NumAxes-1:0][RW-1:0]    ra_q, rb_q;

  assign ready_o = !valid_q || ready_i;

  // Slab test: a miss when the origin lies beyond the slab and the ray does
  // not point back toward it. A zero offset or zero direction counts as away.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      df_mag[a] = df_i[a][DW-1] ? (~df_i[a] + 1'b1) : df_i[a];
      away[a]   = (df_i[a] == '0) || (dir_i[a] == '0) ||
                  (df_i[a][DW-1] == dir_i[a][CoordWidth-1]);
      miss_d[a] = away[a] &&
                  ($signed(df_mag[a]) > $signed({{2{ex_i[a][EW-1]}}, ex_i[a]}));
    end
  end

  // Cross-axis products for the axis pair following each axis in turn.
  for (genvar a = 0; a < NumAxes; a++) begin : g_cross
    localparam int unsigned B = (a + 1) % NumAxes;
    localparam int unsigned C = (a + 2) % NumAxes;
    assign pa_d[a] = $signed(dir_i[B]) * $signed(df_i[C]);
    assign pb_d[a] = $signed(dir_i[C]) * $signed(df_i[B]);
    assign ra_d[a] = $signed(ex_i[B]) * $signed({1'b0, dir_mag_i[C]});
    assign rb_d[a] = $signed(ex_i[C]) * $signed({1'b0, dir_mag_i[B]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Product and slab result registers.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      miss_q <= miss_d;
      for (int a = 0; a < NumAxes; a++) begin
        pa_q[a] <= pa_d[a];
        pb_q[a] <= pb_d[a];
        ra_q[a] <= ra_d[a];
        rb_q[a] <= rb_d[a];
      end
    end
  end

  assign valid_o = valid_q;
  assign miss_o  = miss_q;
  assign pa_o    = pa_q;
  assign pb_o    = pb_q;
  assign ra_o    = ra_q;
  assign rb_o    = rb_q;

endmodule

@@ hw/rtl/rbi_cmp.sv @@
// ----------------------------------------------------------------------------
// rbi_cmp
// Third and fourth pipeline stages: forms |d x diff| and the weighted
// extent sum per cross axis, then compares them and registers the verdict.
// ----------------------------------------------------------------------------
module rbi_cmp
  import rbi_pkg::*;
#(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [NumAxes-1:0]                     miss_i,
  input  logic [NumAxes-1:0][2*CoordWidth+2:0]   pa_i,
  input  logic [NumAxes-1:0][2*CoordWidth+2:0]   pb_i,
  input  logic [NumAxes-1:0][2*CoordWidth+1:0]   ra_i,
  input  logic [NumAxes-1:0][2*CoordWidth+1:0]   rb_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic                                   hit_o
);

  localparam int unsigned PW = 2 * CoordWidth + 3;
  localparam int unsigned RW = 2 * CoordWidth + 2;
  localparam int unsigned LW = 2 * CoordWidth + 4;

  logic                        sum_valid_q, hit_valid_q;
  logic                        sum_ready, hit_ready;
  logic [NumAxes-1:0][LW-1:0]  diff, lhs_d, rhs_d, lhs_q, rhs_q;
  logic [NumAxes-1:0]          miss_q;
  logic [NumAxes-1:0]          sep;
  logic                        hit_d, hit_q;

  assign hit_ready = !hit_valid_q || ready_i;
  assign sum_ready = !sum_valid_q || hit_ready;
  assign ready_o   = sum_ready;

  // Magnitude of the cross product and the weighted half-extent sum.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      diff[a]  = {pa_i[a][PW-1], pa_i[a]} - {pb_i[a][PW-1], pb_i[a]};
      lhs_d[a] = diff[a][LW-1] ? (~diff[a] + 1'b1) : diff[a];
      rhs_d[a] = {{2{ra_i[a][RW-1]}}, ra_i[a]} + {{2{rb_i[a][RW-1]}}, rb_i[a]};
    end
  end

  // A cross axis separates when the magnitude strictly exceeds the sum.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      sep[a] = $signed(lhs_q[a]) > $signed(rhs_q[a]);
    end
    hit_d = !(|miss_q) && !(|sep);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      hit_valid_q <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid_q <= valid_i;
      end
      if (hit_ready) begin
        hit_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && valid_i) begin
      lhs_q  <= lhs_d;
      rhs_q  <= rhs_d;
      miss_q <= miss_i;
    end
    if (hit_ready && sum_valid_q) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = hit_valid_q;
  assign hit_o   = hit_q;

  // The cross-product magnitude never has its sign bit set.
  a_lhs_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid_q |-> !lhs_q[AxisX][LW-1] && !lhs_q[AxisY][LW-1] && !lhs_q[AxisZ][LW-1])
    else $error("cross-product magnitude is negative");

  // A slab miss always turns into a reported miss.
  a_slab_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid_q && hit_ready && (|miss_q)) |=> (hit_valid_q && !hit_q))
    else $error("slab miss reported as a hit");

endmodule
